/* sv/sfd_pkg.sv */
// Shared types and constants for the SBUS frame decoder.
// No dependencies; imported by every module of the block.
package sfd_pkg;

    // Frame geometry
    localparam int FRAME_BYTES   = 25;
    localparam int CHANNEL_COUNT = 16;
    localparam int CHANNEL_BITS  = 11;

    localparam int COUNT_W = $clog2(FRAME_BYTES + 1);
    localparam int ADDR_W  = $clog2(FRAME_BYTES);
    localparam int CH_W    = 4;
    localparam int ACC_W   = CHANNEL_BITS + 7;
    localparam int NB_W    = $clog2(ACC_W + 1);

    localparam logic [7:0] HEADER_BYTE = 8'h0F;
    localparam logic [7:0] FOOTER_BYTE = 8'h00;
    localparam int FAILSAFE_POS = 23;

    // Configuration registers
    localparam int CFG_IDX_W = 3;
    localparam int CFG_REGS  = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_CH0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_CH1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_CH2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_CH3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_REST = 3'd4;

    localparam logic [CHANNEL_BITS-1:0] FS_CH0_RST  = 11'd960;
    localparam logic [CHANNEL_BITS-1:0] FS_CH1_RST  = 11'd980;
    localparam logic [CHANNEL_BITS-1:0] FS_CH2_RST  = 11'd310;
    localparam logic [CHANNEL_BITS-1:0] FS_CH3_RST  = 11'd980;
    localparam logic [CHANNEL_BITS-1:0] FS_REST_RST = 11'd999;

    typedef logic [CFG_REGS-1:0][CHANNEL_BITS-1:0] t_fs_values;

    // Input beat
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       line_idle;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic [CH_W-1:0]         channel_index;
        logic [CHANNEL_BITS-1:0] channel_value;
        logic                    failsafe_active;
        logic                    frame_bad;
        logic                    last_of_frame;
    } t_out_beat;

    // Frame check summary handed from the store to the unpacker
    typedef struct packed {
        logic good;
        logic failsafe;
    } t_frame_info;

endpackage

/* sv/sfd_frame_store.sv */
// Frame byte buffer with byte count and header/footer/failsafe capture.
// Depends on sfd_pkg.
module sfd_frame_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr,
    input  logic [7:0]                i_byte,
    input  logic                      i_close,
    input  logic [sfd_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [7:0]                o_rd_data,
    output sfd_pkg::t_frame_info      o_info
);
    import sfd_pkg::*;

    logic [7:0]         r_mem [FRAME_BYTES];
    logic [7:0]         r_rd_data;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [7:0]         r_header;
    logic [7:0]         r_footer;
    logic [7:0]         r_fs_byte;
    logic               w_room;

    assign w_room = r_count < COUNT_W'(FRAME_BYTES);

    // Byte count: advances on stored bytes, clears on idle event
    always_comb begin
        n_count = r_count;
        if (i_close) begin
            n_count = '0;
        end else if (i_wr && w_room) begin
            n_count = r_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Buffer write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr && w_room) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_byte;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Side copies of the check bytes so the frame check needs no buffer read
    always_ff @(posedge i_clk) begin
        if (i_wr && w_room) begin
            if (r_count == COUNT_W'(0)) begin
                r_header <= i_byte;
            end
            if (r_count == COUNT_W'(FRAME_BYTES - 1)) begin
                r_footer <= i_byte;
            end
            if (r_count == COUNT_W'(FAILSAFE_POS)) begin
                r_fs_byte <= i_byte;
            end
        end
    end

    assign o_rd_data     = r_rd_data;
    assign o_info.good   = (r_count == COUNT_W'(FRAME_BYTES))
                         && (r_header == HEADER_BYTE)
                         && (r_footer == FOOTER_BYTE);
    assign o_info.failsafe = r_fs_byte != 8'h00;

endmodule

/* sv/sfd_unpacker.sv */
// Channel unpack sequencer: one shared shift-merge unit, output register.
// Depends on sfd_pkg; reads bytes from sfd_frame_store.
module sfd_unpacker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_close,
    input  sfd_pkg::t_frame_info       i_info,
    input  sfd_pkg::t_fs_values        i_fs_values,
    output logic [sfd_pkg::ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]                 i_rd_data,
    output logic                       o_busy,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output sfd_pkg::t_out_beat         o_out_data
);
    import sfd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_FETCH = 5'b00100,
        S_MERGE = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNEL_COUNT - 1);

    t_state                  r_state, n_state;
    logic                    r_good, n_good;
    logic                    r_fs, n_fs;
    logic [ADDR_W-1:0]       r_addr, n_addr;
    logic [ACC_W-1:0]        r_acc, n_acc;
    logic [NB_W-1:0]         r_nb, n_nb;
    logic [CH_W-1:0]         r_ch, n_ch;
    logic                    r_out_valid, n_out_valid;
    t_out_beat               r_out, n_out;
    logic                    w_out_free;
    logic [CHANNEL_BITS-1:0] w_fs_value;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Failsafe default for the current channel
    always_comb begin
        unique case (r_ch)
            4'd0:    w_fs_value = i_fs_values[CFG_FS_CH0];
            4'd1:    w_fs_value = i_fs_values[CFG_FS_CH1];
            4'd2:    w_fs_value = i_fs_values[CFG_FS_CH2];
            4'd3:    w_fs_value = i_fs_values[CFG_FS_CH3];
            default: w_fs_value = i_fs_values[CFG_FS_REST];
        endcase
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_good      = r_good;
        n_fs        = r_fs;
        n_addr      = r_addr;
        n_acc       = r_acc;
        n_nb        = r_nb;
        n_ch        = r_ch;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (i_close) begin
                    n_good  = i_info.good;
                    n_fs    = i_info.failsafe;
                    n_addr  = ADDR_W'(1);
                    n_acc   = '0;
                    n_nb    = '0;
                    n_ch    = '0;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_good) begin
                    n_state = S_FETCH;
                end else if (w_out_free) begin
                    // error beat for a bad frame
                    n_out.channel_index   = '0;
                    n_out.channel_value   = '0;
                    n_out.failsafe_active = 1'b0;
                    n_out.frame_bad       = 1'b1;
                    n_out.last_of_frame   = 1'b1;
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            S_FETCH: begin
                if (r_nb >= NB_W'(CHANNEL_BITS)) begin
                    n_state = S_EMIT;
                end else begin
                    // read issued at r_addr this cycle
                    n_addr  = r_addr + ADDR_W'(1);
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                n_acc   = r_acc | (ACC_W'(i_rd_data) << r_nb);
                n_nb    = r_nb + NB_W'(8);
                n_state = S_FETCH;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out.channel_index   = r_ch;
                    n_out.channel_value   = r_fs ? w_fs_value : r_acc[CHANNEL_BITS-1:0];
                    n_out.failsafe_active = r_fs;
                    n_out.frame_bad       = 1'b0;
                    n_out.last_of_frame   = r_ch == CH_LAST;
                    n_out_valid           = 1'b1;
                    n_acc                 = r_acc >> CHANNEL_BITS;
                    n_nb                  = r_nb - NB_W'(CHANNEL_BITS);
                    n_ch                  = r_ch + CH_W'(1);
                    n_state               = (r_ch == CH_LAST) ? S_IDLE : S_FETCH;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_good <= n_good;
        r_fs   <= n_fs;
        r_addr <= n_addr;
        r_acc  <= n_acc;
        r_nb   <= n_nb;
        r_ch   <= n_ch;
        r_out  <= n_out;
    end

    assign o_rd_addr   = r_addr;
    assign o_busy      = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* sv/sbus_frame_decoder.sv */
// SBUS frame decoder top level: handshake, configuration registers.
// Depends on sfd_pkg, sfd_frame_store and sfd_unpacker.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one beat per
//   received byte or idle-line event. Data bytes are taken one per cycle
//   when not stalled and give no output. Bytes past a frame's 25th are dropped.
//   An idle event checks the frame (length 25, header 0x0F, footer 0x00).
//   A bad frame loads one error beat from S_START once the output is free.
//   A good frame gives 16 channel beats, the last flagged last_of_frame.
//   Each channel is built in S_FETCH/S_MERGE steps: the byte buffer has one
//   read port with registered data and one shift-merge unit folds in a byte
//   per S_FETCH/S_MERGE pair; S_EMIT then loads the channel beat once the
//   output register is free. o_in_stall stays high until the last beat is
//   loaded.
//   Output channel (o_out_valid / i_out_stall / o_out_data) has a one-beat
//   output register; a stall holds the beat and pauses the sequencer at the
//   next beat it wants to load.
//   Configuration writes set failsafe defaults; user: idle only, unenforced.
//   Reset (i_rst_n low, synchronous) clears the byte count, the sequencer
//   and the output valid, and loads the default failsafe values.
module sbus_frame_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  sfd_pkg::t_in_beat             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output sfd_pkg::t_out_beat            o_out_data,
    input  logic                          i_cfg_wr,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sfd_pkg::CHANNEL_BITS-1:0] i_cfg_data
);
    import sfd_pkg::*;

    t_fs_values        r_fs_values;
    logic              w_in_acc;
    logic              w_wr;
    logic              w_close;
    logic              w_busy;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [7:0]        w_rd_data;
    t_frame_info       w_info;

    // Input handshake
    assign o_in_stall = w_busy;
    assign w_in_acc   = i_in_valid && !w_busy;
    assign w_wr       = w_in_acc && !i_in_data.line_idle;
    assign w_close    = w_in_acc && i_in_data.line_idle;

    // Failsafe default registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs_values[CFG_FS_CH0]  <= FS_CH0_RST;
            r_fs_values[CFG_FS_CH1]  <= FS_CH1_RST;
            r_fs_values[CFG_FS_CH2]  <= FS_CH2_RST;
            r_fs_values[CFG_FS_CH3]  <= FS_CH3_RST;
            r_fs_values[CFG_FS_REST] <= FS_REST_RST;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_idx)
                CFG_FS_CH0:  r_fs_values[CFG_FS_CH0]  <= i_cfg_data;
                CFG_FS_CH1:  r_fs_values[CFG_FS_CH1]  <= i_cfg_data;
                CFG_FS_CH2:  r_fs_values[CFG_FS_CH2]  <= i_cfg_data;
                CFG_FS_CH3:  r_fs_values[CFG_FS_CH3]  <= i_cfg_data;
                CFG_FS_REST: r_fs_values[CFG_FS_REST] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sfd_frame_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_byte    (i_in_data.rx_byte),
        .i_close   (w_close),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .o_info    (w_info)
    );

    sfd_unpacker u_unpack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_close     (w_close),
        .i_info      (w_info),
        .i_fs_values (r_fs_values),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_busy      (w_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
